@@ hdl/rsp_pkg.sv @@
// ----------------------------------------------------------------------------
// rsp_pkg
// Item types and command/status codes for the random sampling pool.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rsp_pkg;

    localparam logic [2:0] CMD_CLEAR   = 3'd0;
    localparam logic [2:0] CMD_APPEND  = 3'd1;
    localparam logic [2:0] CMD_FILL    = 3'd2;
    localparam logic [2:0] CMD_DRAW_WO = 3'd3;
    localparam logic [2:0] CMD_DRAW_W  = 3'd4;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [31:0] item_value;
        logic [10:0] fill_count;
        logic [15:0] random_fraction;
    } cmd_item_t;

    typedef struct packed {
        logic [31:0] drawn_value;
        logic [1:0]  status;
        logic [10:0] items_left;
    } res_item_t;

endpackage

`default_nettype wire

@@ hdl/random_sampling_pool.sv @@
// ----------------------------------------------------------------------------
// random_sampling_pool
// Pool of up to DEPTH 32-bit items with clear, append, identity fill and
// draws with or without replacement (swap-with-last removal).
// ----------------------------------------------------------------------------
// One command item is taken at a time and gives exactly one result item.
// A draw goes through S_READ and S_DRAW: the slot product is registered at
// acceptance, the synchronous pool read is made in S_READ, and S_DRAW gives
// the result and the write-back of the last live item. Clear, append, a
// zero fill and a failed draw go straight to S_EXEC. An identity fill
// writes one entry per cycle in S_FILL through the single write port, then
// completes in S_EXEC. The result sits in an output register; a stalled
// result holds off only the completion of the next command. Pool entries
// are not cleared at reset; only slots below the live count are ever used.
`timescale 1ns / 1ps
`default_nettype none

module random_sampling_pool
    import rsp_pkg::*;
#(
    parameter int DEPTH         = 1024,
    parameter int FRACTION_BITS = 16
)
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      cmd_valid,
    output logic           cmd_stall,
    input  wire cmd_item_t cmd_item,
    output logic           res_valid,
    input  wire logic      res_stall,
    output res_item_t      res_item
);

    localparam int AW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW  = $clog2(DEPTH + 1);
    localparam int FW  = (CW > 11) ? CW : 11;
    localparam int FRW = (FRACTION_BITS < 16) ? FRACTION_BITS : 16;
    localparam int PW  = FRW + CW;

    localparam logic [CW-1:0] DEPTH_CW = CW'(DEPTH);
    localparam logic [FW-1:0] DEPTH_FW = FW'(DEPTH);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_EXEC = 5'b00010,
        S_FILL = 5'b00100,
        S_READ = 5'b01000,
        S_DRAW = 5'b10000
    } state_t;

    state_t          state_reg,    state_next;
    logic [CW-1:0]   count_reg,    count_next;
    logic [CW-1:0]   fill_idx_reg, fill_idx_next;
    logic [CW-1:0]   fill_sat_reg, fill_sat_next;
    logic [2:0]      op_reg,       op_next;
    logic [31:0]     item_reg,     item_next;
    logic [PW-1:0]   prod_reg,     prod_next;
    logic            res_valid_reg, res_valid_next;
    res_item_t       res_reg,      res_next;

    logic [31:0]     mem [DEPTH];
    logic [31:0]     rd_a_reg;
    logic [31:0]     rd_b_reg;
    logic [AW-1:0]   rd_a_addr;
    logic [AW-1:0]   rd_b_addr;
    logic            we;
    logic [AW-1:0]   waddr;
    logic [31:0]     wdata;

    logic [FW-1:0]   fill_ext;
    logic [CW-1:0]   fill_sat;
    logic [FRW-1:0]  frac_m;
    logic            out_free;
    logic            fin;

    assign fill_ext = FW'(cmd_item.fill_count);
    assign fill_sat = (fill_ext > DEPTH_FW) ? DEPTH_CW : CW'(fill_ext);
    assign frac_m   = cmd_item.random_fraction[FRW-1:0];
    assign out_free = !res_valid_reg || !res_stall;

    // slot = floor(fraction * count / 2^FRACTION_BITS), always below count
    assign rd_a_addr = AW'(prod_reg >> FRACTION_BITS);
    assign rd_b_addr = AW'(count_reg - CW'(1));

    assign cmd_stall = (state_reg != S_IDLE);
    assign res_valid = res_valid_reg;
    assign res_item  = res_reg;

    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        fill_idx_next = fill_idx_reg;
        fill_sat_next = fill_sat_reg;
        op_next       = op_reg;
        item_next     = item_reg;
        prod_next     = prod_reg;
        res_next      = res_reg;
        fin           = 1'b0;
        we            = 1'b0;
        waddr         = rd_a_addr;
        wdata         = rd_b_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    op_next       = cmd_item.cmd;
                    item_next     = cmd_item.item_value;
                    fill_sat_next = fill_sat;
                    fill_idx_next = '0;
                    prod_next     = PW'(frac_m) * PW'(count_reg);
                    if ((cmd_item.cmd == CMD_DRAW_WO || cmd_item.cmd == CMD_DRAW_W)
                        && count_reg != '0)
                    begin
                        state_next = S_READ;
                    end
                    else if (cmd_item.cmd == CMD_FILL && fill_sat != '0)
                    begin
                        state_next = S_FILL;
                    end
                    else
                    begin
                        state_next = S_EXEC;
                    end
                end
            end
            S_FILL:
            begin
                we            = 1'b1;
                waddr         = fill_idx_reg[AW-1:0];
                wdata         = 32'(fill_idx_reg);
                fill_idx_next = fill_idx_reg + CW'(1);
                if (fill_idx_reg == fill_sat_reg - CW'(1))
                begin
                    state_next = S_EXEC;
                end
            end
            S_READ:
            begin
                state_next = S_DRAW;
            end
            S_DRAW:
            begin
                if (out_free)
                begin
                    fin                  = 1'b1;
                    res_next.drawn_value = rd_a_reg;
                    res_next.status      = ST_OK;
                    if (op_reg == CMD_DRAW_WO)
                    begin
                        // move the last live item into the drawn slot
                        we         = 1'b1;
                        waddr      = rd_a_addr;
                        wdata      = rd_b_reg;
                        count_next = count_reg - CW'(1);
                    end
                    res_next.items_left = 11'(count_next);
                    state_next          = S_IDLE;
                end
            end
            S_EXEC:
            begin
                if (out_free)
                begin
                    fin                  = 1'b1;
                    res_next.drawn_value = '0;
                    res_next.status      = ST_OK;
                    unique case (op_reg)
                        CMD_CLEAR:
                        begin
                            count_next = '0;
                        end
                        CMD_APPEND:
                        begin
                            if (count_reg == DEPTH_CW)
                            begin
                                res_next.status = ST_FULL;
                            end
                            else
                            begin
                                we         = 1'b1;
                                waddr      = count_reg[AW-1:0];
                                wdata      = item_reg;
                                count_next = count_reg + CW'(1);
                            end
                        end
                        CMD_FILL:
                        begin
                            count_next = fill_sat_reg;
                        end
                        CMD_DRAW_WO, CMD_DRAW_W:
                        begin
                            res_next.status = ST_EMPTY;
                        end
                        default:
                        begin
                            count_next = count_reg;
                        end
                    endcase
                    res_next.items_left = 11'(count_next);
                    state_next          = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (fin)
        begin
            res_valid_next = 1'b1;
        end
        else if (!res_stall)
        begin
            res_valid_next = 1'b0;
        end
        else
        begin
            res_valid_next = res_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        fill_idx_reg <= fill_idx_next;
        fill_sat_reg <= fill_sat_next;
        op_reg       <= op_next;
        item_reg     <= item_next;
        prod_reg     <= prod_next;
        res_reg      <= res_next;
    end

    // pool memory: one write port, two registered read ports
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rd_a_reg <= mem[rd_a_addr];
        rd_b_reg <= mem[rd_b_addr];
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= DEPTH_CW)
        else $error("live count above pool depth");

    a_read_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_READ |-> count_reg != '0)
        else $error("draw read issued on empty pool");

    a_slot_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_READ |-> CW'(rd_a_addr) < count_reg)
        else $error("drawn slot outside live range");

    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid_reg) |-> $past(state_reg == S_EXEC || state_reg == S_DRAW))
        else $error("result raised outside a completing state");

endmodule

`default_nettype wire
